// File: rtl/lts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared types and codes for the lottery ticket scheduler and its slot RAM.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int TKT_W   = 6;
    localparam int LVL_W   = 4;
    localparam int QNT_W   = 16;
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 2;
    localparam int BC_W    = 32;
    localparam int DRAW_W  = 16;
    localparam int CFG_W   = 6;
    localparam int CIDX_W  = 2;

    localparam logic [OP_W-1:0] OP_START_SYS = 3'd0;
    localparam logic [OP_W-1:0] OP_START_INH = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPIRED   = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_LEVEL = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_STATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_PARENT = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_TICKET_CAP   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WINNER_LEVEL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LOSER_LEVEL  = 2'd2;

    localparam logic [TKT_W-1:0] SYS_TICKETS = 6'd10;
    localparam logic [TKT_W-1:0] INH_TICKETS = 6'd5;

    typedef struct packed {
        logic [TKT_W-1:0] tickets;
        logic [LVL_W-1:0] level;
        logic [QNT_W-1:0] quantum;
    } slot_word_t;

endpackage

// File: rtl/lts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lts_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lottery_ticket_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Slot table with start, stop, set-level and quantum-expiry commands; a
// quantum expiry runs a ticket lottery over all in-use user slots if their ticket total is nonzero.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time and holds in_stall high
// until its last result has been produced. A command is checked, reads its
// slot (an inherited start also the parent slot) and is applied; a rejected
// command ends after the check. The slot RAM has one read port, so on a
// quantum expiry the ticket sum and the lottery each visit a slot in a read
// state and an accumulate state; between them the remainder of the draw by
// the ticket total is formed one bit per cycle. Results that wait on
// out_stall hold the block longer. No clearing pass is needed after reset.
module lottery_ticket_scheduler #(
    parameter int SLOTS  = 32,
    parameter int LEVELS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lts_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [lts_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lts_pkg::OP_W-1:0]    op,
    input  logic [lts_pkg::SLOT_W-1:0]  slot,
    input  logic [lts_pkg::SLOT_W-1:0]  parent_slot,
    input  logic [lts_pkg::LVL_W-1:0]   level,
    input  logic [lts_pkg::QNT_W-1:0]   quantum,
    input  logic [lts_pkg::BC_W-1:0]    blocked_count,
    input  logic [lts_pkg::DRAW_W-1:0]  draw,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lts_pkg::STAT_W-1:0]  status,
    output logic [lts_pkg::SLOT_W-1:0]  out_slot,
    output logic [lts_pkg::LVL_W-1:0]   out_level,
    output logic [lts_pkg::QNT_W-1:0]   out_quantum,
    output logic                        last
);

    import lts_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int TOT_W = $clog2(SLOTS * 63 + 1);
    localparam int WORD_W = $bits(slot_word_t);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHK    = 11'b00000000010,
        S_RDS    = 11'b00000000100,
        S_RDP    = 11'b00000001000,
        S_APPLY  = 11'b00000010000,
        S_SUM_RD = 11'b00000100000,
        S_SUM_AC = 11'b00001000000,
        S_PEND   = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_LOT_RD = 11'b01000000000,
        S_LOT_AC = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [TKT_W-1:0] cap_reg;
    logic [LVL_W-1:0] win_lvl_reg;
    logic [LVL_W-1:0] lose_lvl_reg;

    logic [OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] parent_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [QNT_W-1:0]  qnt_reg;
    logic [BC_W-1:0]   bc_reg;
    logic [DRAW_W-1:0] draw_reg;

    logic [SLOTS-1:0] in_use_reg, in_use_next;
    logic [SLOTS-1:0] tkt_ok_reg, tkt_ok_next;
    logic [BC_W-1:0]  hbc_reg, hbc_next;

    slot_word_t sw_reg, sw_next;
    logic       sok_reg, sok_next;
    logic [QNT_W-1:0] pq_reg, pq_next;

    logic [SW-1:0]    idx_reg, idx_next;
    logic [SW-1:0]    last_idx_reg, last_idx_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0] cum_reg, cum_next;
    logic [TOT_W:0]   rem_reg, rem_next;
    logic [3:0]       bit_reg, bit_next;
    logic             won_reg, won_next;

    logic              ov_reg, ov_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [SLOT_W-1:0] os_reg, os_next;
    logic [LVL_W-1:0]  ol_reg, ol_next;
    logic [QNT_W-1:0]  oq_reg, oq_next;
    logic              ol_last_reg, ol_last_next;

    logic [LVL_W-1:0] pl_reg, pl_next;
    logic [QNT_W-1:0] pqn_reg, pqn_next;

    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    slot_word_t    ram_wdata;
    logic [SW-1:0] ram_raddr;
    slot_word_t    ram_rdata;

    logic [SW-1:0]     s_idx;
    logic [SW-1:0]     p_idx;
    logic              out_free;
    logic [TKT_W-1:0]  eff_cap;
    logic [TKT_W-1:0]  cur_tkt;
    logic [TKT_W-1:0]  rd_tkt;
    logic              rd_qual;
    logic [TOT_W-1:0]  cum_sum;
    logic [TOT_W:0]    rem_shift;
    logic              err_hit;
    logic [STAT_W-1:0] err_code;

    function automatic logic [TKT_W-1:0] clamp_tkt(input logic [TKT_W:0] t,
                                                   input logic [TKT_W-1:0] c);
        logic [TKT_W-1:0] r;
        begin
            if (t == '0)
            begin
                r = TKT_W'(1);
            end
            else if (t > {1'b0, c})
            begin
                r = c;
            end
            else
            begin
                r = t[TKT_W-1:0];
            end
            return r;
        end
    endfunction

    lts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_idx    = SW'(slot_reg);
    assign p_idx    = SW'(parent_reg);
    assign out_free = !ov_reg || !out_stall;
    assign eff_cap  = (cap_reg == '0) ? TKT_W'(1) : cap_reg;
    assign cur_tkt  = sok_reg ? sw_reg.tickets : '0;
    assign rd_tkt   = tkt_ok_reg[idx_reg] ? ram_rdata.tickets : '0;
    assign rd_qual  = in_use_reg[idx_reg] && (ram_rdata.level >= win_lvl_reg);
    assign cum_sum  = cum_reg + TOT_W'(rd_tkt);
    assign rem_shift = {rem_reg[TOT_W-1:0], draw_reg[4'd15 - bit_reg]};

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign out_slot    = os_reg;
    assign out_level   = ol_reg;
    assign out_quantum = oq_reg;
    assign last        = ol_last_reg;

    always_comb
    begin
        err_hit  = 1'b0;
        err_code = ST_OK;
        if (op_reg > OP_SET_LEVEL || {1'b0, slot_reg} >= (SLOT_W + 1)'(SLOTS))
        begin
            err_hit  = 1'b1;
            err_code = ST_BAD_STATE;
        end
        else if (op_reg == OP_START_SYS || op_reg == OP_START_INH)
        begin
            if (in_use_reg[s_idx])
            begin
                err_hit  = 1'b1;
                err_code = ST_BAD_STATE;
            end
            else if ({1'b0, lvl_reg} >= (LVL_W + 1)'(LEVELS))
            begin
                err_hit  = 1'b1;
                err_code = ST_BAD_LEVEL;
            end
            else if (op_reg == OP_START_INH &&
                     ({1'b0, parent_reg} >= (SLOT_W + 1)'(SLOTS) || !in_use_reg[p_idx]))
            begin
                err_hit  = 1'b1;
                err_code = ST_BAD_PARENT;
            end
        end
        else if (!in_use_reg[s_idx])
        begin
            err_hit  = 1'b1;
            err_code = ST_BAD_STATE;
        end
        else if (op_reg == OP_SET_LEVEL && {1'b0, lvl_reg} >= (LVL_W + 1)'(LEVELS))
        begin
            err_hit  = 1'b1;
            err_code = ST_BAD_LEVEL;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_use_next   = in_use_reg;
        tkt_ok_next   = tkt_ok_reg;
        hbc_next      = hbc_reg;
        sw_next       = sw_reg;
        sok_next      = sok_reg;
        pq_next       = pq_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        total_next    = total_reg;
        cum_next      = cum_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        won_next      = won_reg;
        pl_next       = pl_reg;
        pqn_next      = pqn_reg;
        ov_next       = ov_reg && out_stall;
        st_next       = st_reg;
        os_next       = os_reg;
        ol_next       = ol_reg;
        oq_next       = oq_reg;
        ol_last_next  = ol_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = s_idx;
        ram_wdata     = sw_reg;
        ram_raddr     = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                ram_raddr = s_idx;
                if (err_hit)
                begin
                    if (out_free)
                    begin
                        ov_next      = 1'b1;
                        st_next      = err_code;
                        os_next      = slot_reg;
                        ol_next      = '0;
                        oq_next      = '0;
                        ol_last_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_RDS;
                end
            end
            S_RDS:
            begin
                ram_raddr = p_idx;
                sw_next   = ram_rdata;
                sok_next  = tkt_ok_reg[s_idx];
                state_next = (op_reg == OP_START_INH) ? S_RDP : S_APPLY;
            end
            S_RDP:
            begin
                pq_next    = ram_rdata.quantum;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (op_reg == OP_EXPIRED)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sw_reg;
                    if (sw_reg.level >= win_lvl_reg)
                    begin
                        if (bc_reg > hbc_reg)
                        begin
                            ram_wdata.tickets = clamp_tkt({1'b0, cur_tkt} + 7'd1, eff_cap);
                        end
                        else
                        begin
                            ram_wdata.tickets = clamp_tkt((cur_tkt == '0) ? 7'd0 :
                                                          {1'b0, cur_tkt} - 7'd1, eff_cap);
                        end
                        tkt_ok_next[s_idx] = 1'b1;
                    end
                    if (bc_reg > hbc_reg)
                    begin
                        hbc_next = bc_reg;
                    end
                    pl_next    = sw_reg.level;
                    pqn_next   = sw_reg.quantum;
                    idx_next   = '0;
                    total_next = '0;
                    state_next = S_SUM_RD;
                end
                else if (out_free)
                begin
                    ov_next      = 1'b1;
                    st_next      = ST_OK;
                    os_next      = slot_reg;
                    ol_last_next = 1'b1;
                    state_next   = S_IDLE;
                    case (op_reg)
                        OP_START_SYS, OP_START_INH:
                        begin
                            ram_we = 1'b1;
                            ram_wdata.level   = (op_reg == OP_START_SYS) ? lvl_reg
                                                                         : lose_lvl_reg;
                            ram_wdata.quantum = (op_reg == OP_START_SYS) ? qnt_reg : pq_reg;
                            if (ram_wdata.level >= win_lvl_reg)
                            begin
                                ram_wdata.tickets = clamp_tkt({1'b0,
                                    (op_reg == OP_START_SYS) ? SYS_TICKETS : INH_TICKETS},
                                    eff_cap);
                                tkt_ok_next[s_idx] = 1'b1;
                            end
                            in_use_next[s_idx] = 1'b1;
                            ol_next = ram_wdata.level;
                            oq_next = ram_wdata.quantum;
                        end
                        OP_STOP:
                        begin
                            in_use_next[s_idx] = 1'b0;
                            ol_next = '0;
                            oq_next = '0;
                        end
                        default:
                        begin
                            ram_we = 1'b1;
                            ram_wdata.level = lvl_reg;
                            ol_next = lvl_reg;
                            oq_next = sw_reg.quantum;
                        end
                    endcase
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_AC;
            end
            S_SUM_AC:
            begin
                if (rd_qual)
                begin
                    total_next    = total_reg + TOT_W'(rd_tkt);
                    last_idx_next = idx_reg;
                end
                if (idx_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_PEND;
                end
                else
                begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_PEND:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    st_next      = ST_OK;
                    os_next      = slot_reg;
                    ol_next      = pl_reg;
                    oq_next      = pqn_reg;
                    ol_last_next = (total_reg == '0);
                    rem_next     = '0;
                    bit_next     = '0;
                    state_next   = (total_reg == '0) ? S_IDLE : S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_shift >= {1'b0, total_reg})
                begin
                    rem_next = rem_shift - {1'b0, total_reg};
                end
                else
                begin
                    rem_next = rem_shift;
                end
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'd15)
                begin
                    idx_next   = '0;
                    cum_next   = '0;
                    won_next   = 1'b0;
                    state_next = S_LOT_RD;
                end
            end
            S_LOT_RD:
            begin
                state_next = S_LOT_AC;
            end
            S_LOT_AC:
            begin
                if (!rd_qual)
                begin
                    if (idx_reg == SW'(SLOTS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SW'(1);
                        state_next = S_LOT_RD;
                    end
                end
                else if (out_free)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = ram_rdata;
                    ram_wdata.tickets = rd_tkt;
                    cum_next  = cum_sum;
                    if (!won_reg && {1'b0, cum_sum} > rem_reg)
                    begin
                        won_next = 1'b1;
                        ram_wdata.level = win_lvl_reg;
                    end
                    else
                    begin
                        ram_wdata.level = lose_lvl_reg;
                        if (rd_tkt < eff_cap)
                        begin
                            ram_wdata.tickets = rd_tkt + TKT_W'(1);
                        end
                    end
                    tkt_ok_next[idx_reg] = 1'b1;
                    ov_next      = 1'b1;
                    st_next      = ST_OK;
                    os_next      = SLOT_W'(idx_reg);
                    ol_next      = ram_wdata.level;
                    oq_next      = ram_rdata.quantum;
                    ol_last_next = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SW'(1);
                        state_next = S_LOT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= 6'd20;
            win_lvl_reg  <= 4'd13;
            lose_lvl_reg <= 4'd14;
            in_use_reg   <= '0;
            tkt_ok_reg   <= '0;
            hbc_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            tkt_ok_reg <= tkt_ok_next;
            hbc_reg    <= hbc_next;
            ov_reg     <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICKET_CAP:   cap_reg      <= cfg_data;
                    CFG_WINNER_LEVEL: win_lvl_reg  <= cfg_data[LVL_W-1:0];
                    CFG_LOSER_LEVEL:  lose_lvl_reg <= cfg_data[LVL_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg     <= op;
            slot_reg   <= slot;
            parent_reg <= parent_slot;
            lvl_reg    <= level;
            qnt_reg    <= quantum;
            bc_reg     <= blocked_count;
            draw_reg   <= draw;
        end
        sw_reg       <= sw_next;
        sok_reg      <= sok_next;
        pq_reg       <= pq_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        total_reg    <= total_next;
        cum_reg      <= cum_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        won_reg      <= won_next;
        pl_reg       <= pl_next;
        pqn_reg      <= pqn_next;
        st_reg       <= st_next;
        os_reg       <= os_next;
        ol_reg       <= ol_next;
        oq_reg       <= oq_next;
        ol_last_reg  <= ol_last_next;
    end

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_APPLY || state_reg == S_LOT_AC))
        else $error("slot RAM written outside a write state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (total_reg != '0))
        else $error("remainder unit started with a zero ticket total");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOT_RD) |-> (rem_reg < {1'b0, total_reg}))
        else $error("lottery draw not below the ticket total");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && st_reg != ST_OK) |-> ol_last_reg)
        else $error("error result not marked as final");

endmodule

// File: sim/tb_lottery_ticket_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler testbench
// Drives command transactions with random gaps and result stalls, predicts
// every result from a behavioral copy of the slot table, and checks each
// result transaction field by field across several register settings.
// ----------------------------------------------------------------------------
module tb_lottery_ticket_scheduler;
    import lts_pkg::*;

    localparam int NSLOTS = 32;
    localparam int NLEVELS = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] parent;
        logic [LVL_W-1:0]  level;
        logic [QNT_W-1:0]  quantum;
        logic [BC_W-1:0]   bcount;
        logic [DRAW_W-1:0] draw;
        int                gap;
    } command_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  level;
        logic [QNT_W-1:0]  quantum;
        logic              fin;
    } sched_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] op = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [SLOT_W-1:0] parent_slot = '0;
    logic [LVL_W-1:0] level = '0;
    logic [QNT_W-1:0] quantum = '0;
    logic [BC_W-1:0] blocked_count = '0;
    logic [DRAW_W-1:0] draw = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] out_slot;
    logic [LVL_W-1:0] out_level;
    logic [QNT_W-1:0] out_quantum;
    logic res_last;

    command_t pending_cmds[$];
    sched_t expected_sched[$];
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    bit quiet = 0;
    int errors = 0;
    int cmds_queued = 0;
    int cmds_done = 0;
    int results_done = 0;
    int lotteries = 0;
    int cycles = 0;

    logic [TKT_W-1:0] m_cap;
    logic [LVL_W-1:0] m_win;
    logic [LVL_W-1:0] m_lose;
    bit m_used[NSLOTS];
    int m_tickets[NSLOTS];
    logic [LVL_W-1:0] m_level[NSLOTS];
    logic [QNT_W-1:0] m_quantum[NSLOTS];
    logic [BC_W-1:0] m_highest;

    lottery_ticket_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .slot(slot), .parent_slot(parent_slot), .level(level),
        .quantum(quantum), .blocked_count(blocked_count), .draw(draw),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_slot(out_slot), .out_level(out_level),
        .out_quantum(out_quantum), .last(res_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int cap_limit();
        return (m_cap == 0) ? 1 : int'(m_cap);
    endfunction

    function automatic bit is_user(logic [LVL_W-1:0] l);
        return l >= m_win;
    endfunction

    function automatic int clamp(int t);
        if (t < 1)
            return 1;
        if (t > cap_limit())
            return cap_limit();
        return t;
    endfunction

    function automatic void push_sched(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] s,
                                       logic [LVL_W-1:0] l, logic [QNT_W-1:0] q);
        sched_t r;
        r.status = st;
        r.slot = s;
        r.level = l;
        r.quantum = q;
        r.fin = 1'b1;
        expected_sched.push_back(r);
    endfunction

    function automatic void schedule_command(command_t c);
        int s;
        int total;
        int w;
        int cum;
        bit won;
        logic [LVL_W-1:0] nl;
        logic [QNT_W-1:0] nq;
        int nt;
        sched_t r;
        s = c.slot;
        if (c.op > OP_SET_LEVEL)
        begin
            push_sched(ST_BAD_STATE, c.slot, '0, '0);
            return;
        end
        if (c.op == OP_START_SYS || c.op == OP_START_INH)
        begin
            if (m_used[s])
            begin
                push_sched(ST_BAD_STATE, c.slot, '0, '0);
                return;
            end
            if (c.level >= NLEVELS)
            begin
                push_sched(ST_BAD_LEVEL, c.slot, '0, '0);
                return;
            end
            if (c.op == OP_START_SYS)
            begin
                nl = c.level;
                nq = c.quantum;
                nt = SYS_TICKETS;
            end
            else
            begin
                if (!m_used[c.parent])
                begin
                    push_sched(ST_BAD_PARENT, c.slot, '0, '0);
                    return;
                end
                nl = m_lose;
                nq = m_quantum[c.parent];
                nt = INH_TICKETS;
            end
            m_level[s] = nl;
            m_quantum[s] = nq;
            if (is_user(nl))
                m_tickets[s] = clamp(nt);
            m_used[s] = 1;
            push_sched(ST_OK, c.slot, nl, nq);
            return;
        end
        if (!m_used[s])
        begin
            push_sched(ST_BAD_STATE, c.slot, '0, '0);
            return;
        end
        if (c.op == OP_STOP)
        begin
            m_used[s] = 0;
            push_sched(ST_OK, c.slot, '0, '0);
            return;
        end
        if (c.op == OP_SET_LEVEL)
        begin
            m_level[s] = c.level;
            push_sched(ST_OK, c.slot, c.level, m_quantum[s]);
            return;
        end
        if (c.bcount > m_highest)
        begin
            m_highest = c.bcount;
            if (is_user(m_level[s]))
                m_tickets[s] = clamp(m_tickets[s] + 1);
        end
        else if (is_user(m_level[s]))
            m_tickets[s] = clamp(m_tickets[s] - 1);
        push_sched(ST_OK, c.slot, m_level[s], m_quantum[s]);
        total = 0;
        for (int i = 0; i < NSLOTS; i++)
            if (m_used[i] && is_user(m_level[i]))
                total += m_tickets[i];
        if (total == 0)
            return;
        lotteries++;
        w = int'(c.draw) % total;
        cum = 0;
        won = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (!m_used[i] || !is_user(m_level[i]))
                continue;
            cum += m_tickets[i];
            if (!won && cum > w)
            begin
                won = 1;
                m_level[i] = m_win;
            end
            else
            begin
                if (m_tickets[i] < cap_limit())
                    m_tickets[i] += 1;
                m_level[i] = m_lose;
            end
            r = expected_sched.pop_back();
            r.fin = 1'b0;
            expected_sched.push_back(r);
            push_sched(ST_OK, i[SLOT_W-1:0], m_level[i], m_quantum[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                schedule_command(command_t'{op, slot, parent_slot, level, quantum,
                                            blocked_count, draw, 0});
                cmds_done++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    command_t c;
                    c = pending_cmds.pop_front();
                    op <= c.op;
                    slot <= c.slot;
                    parent_slot <= c.parent;
                    level <= c.level;
                    quantum <= c.quantum;
                    blocked_count <= c.bcount;
                    draw <= c.draw;
                    in_valid <= 1'b1;
                    gap_left <= c.gap;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end
        else
        begin
            int sl;
            int hl;
            sl = stall_left;
            hl = hold_left;
            if (out_valid && !out_stall)
            begin
                sched_t e;
                results_done++;
                if (expected_sched.size() == 0)
                begin
                    $error("unexpected result: slot %0d status %0d", out_slot, status);
                    errors++;
                end
                else
                begin
                    e = expected_sched.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        errors++;
                    end
                    if (out_slot !== e.slot)
                    begin
                        $error("out_slot: expected %0d, got %0d", e.slot, out_slot);
                        errors++;
                    end
                    if (out_level !== e.level)
                    begin
                        $error("out_level: expected %0d, got %0d", e.level, out_level);
                        errors++;
                    end
                    if (out_quantum !== e.quantum)
                    begin
                        $error("out_quantum: expected %0d, got %0d", e.quantum, out_quantum);
                        errors++;
                    end
                    if (res_last !== e.fin)
                    begin
                        $error("last: expected %0d, got %0d", e.fin, res_last);
                        errors++;
                    end
                end
                sl = quiet ? 0 : $urandom_range(0, 4);
            end
            else if (sl > 0)
                sl--;
            if (hold_req && !hold_done)
            begin
                hold_done <= 1'b1;
                hl = 400;
            end
            else if (hl > 0)
                hl--;
            stall_left <= sl;
            hold_left <= hl;
            out_stall <= (sl > 0) || (hl > 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_cmd(logic [OP_W-1:0] o, int s, int p, int l, int q,
                           logic [BC_W-1:0] bc, int d);
        command_t c;
        c.op = o;
        c.slot = s;
        c.parent = p;
        c.level = l;
        c.quantum = q;
        c.bcount = bc;
        c.draw = d;
        c.gap = quiet ? 0 : $urandom_range(0, 4);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic add_random(int n);
        int pick;
        logic [BC_W-1:0] bc;
        logic [OP_W-1:0] o;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                o = OP_START_SYS;
            else if (pick < 40)
                o = OP_START_INH;
            else if (pick < 75)
                o = OP_EXPIRED;
            else if (pick < 83)
                o = OP_STOP;
            else if (pick < 95)
                o = OP_SET_LEVEL;
            else
                o = OP_W'($urandom_range(5, 7));
            case ($urandom_range(0, 3))
                0: bc = $urandom;
                1: bc = $urandom_range(0, 3);
                default: bc = m_highest + $urandom_range(0, 2) - 1;
            endcase
            add_cmd(o, $urandom_range(0, NSLOTS - 1), $urandom_range(0, NSLOTS - 1),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(10, 15),
                    $urandom_range(0, 65535), bc, $urandom_range(0, 65535));
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmds_done < cmds_queued || in_valid ||
               expected_sched.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int cap, int win, int lose);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TICKET_CAP;
        cfg_data <= cap;
        @(posedge clk);
        cfg_index <= CFG_WINNER_LEVEL;
        cfg_data <= win;
        @(posedge clk);
        cfg_index <= CFG_LOSER_LEVEL;
        cfg_data <= lose;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_cap = cap;
        m_win = win;
        m_lose = lose;
    endtask

    initial
    begin
        m_cap = 20;
        m_win = 13;
        m_lose = 14;
        m_highest = '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            m_used[i] = 0;
            m_tickets[i] = 0;
            m_level[i] = '0;
            m_quantum[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        add_cmd(OP_START_SYS, 0, 0, 15, 16'hFFFF, 0, 0);
        add_cmd(OP_START_SYS, 0, 0, 15, 1, 0, 0);
        add_cmd(OP_START_SYS, 1, 0, 13, 0, 0, 0);
        add_cmd(OP_START_INH, 2, 0, 0, 0, 0, 0);
        add_cmd(OP_START_INH, 3, 31, 0, 0, 0, 0);
        add_cmd(OP_START_SYS, 4, 0, 0, 16'h1234, 0, 0);
        add_cmd(OP_EXPIRED, 0, 0, 0, 0, 1000, 16'hFFFF);
        add_cmd(OP_EXPIRED, 1, 0, 0, 0, 0, 0);
        add_cmd(OP_EXPIRED, 4, 0, 0, 0, 5, 7);
        add_cmd(OP_SET_LEVEL, 4, 0, 15, 0, 0, 0);
        add_cmd(OP_SET_LEVEL, 5, 0, 14, 0, 0, 0);
        add_cmd(OP_STOP, 4, 0, 0, 0, 0, 0);
        add_cmd(OP_STOP, 4, 0, 0, 0, 0, 0);
        add_cmd(3'd5, 31, 0, 0, 0, 0, 0);
        add_cmd(3'd6, 31, 0, 0, 0, 0, 0);
        add_cmd(3'd7, 31, 0, 0, 0, 0, 0);
        add_cmd(OP_EXPIRED, 31, 0, 0, 0, 0, 0);
        add_cmd(OP_START_SYS, 31, 0, 14, 16'hAAAA, 0, 0);
        add_cmd(OP_START_INH, 30, 31, 0, 0, 0, 0);
        add_cmd(OP_EXPIRED, 31, 0, 0, 0, 0, 16'h1234);
        add_cmd(OP_SET_LEVEL, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_EXPIRED, 2, 0, 0, 0, 999, 3);
        wait_idle();

        set_config(63, 15, 0);
        hold_req = 1;
        add_random(45);
        wait_idle();

        set_config(1, 0, 15);
        quiet = 1;
        add_random(40);
        wait_idle();
        quiet = 0;

        set_config(0, 8, 3);
        add_random(45);
        wait_idle();

        set_config(37, 12, 15);
        add_random(45);
        wait_idle();

        set_config(5, 15, 15);
        add_cmd(OP_EXPIRED, $urandom_range(0, NSLOTS - 1), 0, 0, 0, 32'hFFFF_FFFF, 0);
        add_random(60);
        wait_idle();

        $display("Covered %0d commands and %0d results, including %0d lotteries,",
                 cmds_done, results_done, lotteries);
        $display("over six register settings with stalls on both sides.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: lottery_ticket_scheduler.f
rtl/lts_pkg.sv
rtl/lts_ram.sv
rtl/lottery_ticket_scheduler.sv
sim/tb_lottery_ticket_scheduler.sv
